// ===== rtl/core/indexed_min_heap_queue_unit_assert.svh =====
// Assertion macros for the indexed heap queue.
// Each check is switched off as a group when ASSERT_OFF is defined.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// The condition implies the consequence in the same cycle.
`define IMHQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heap queue: same-cycle check failed");
// The condition implies the consequence in the next cycle.
`define IMHQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heap queue: next-cycle check failed");
`else
`define IMHQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IMHQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/imhq_pkg.sv =====
package imhq_pkg;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_CHANGE  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_ABSENT  = 3'd4;

    localparam int ID_W  = 8;
    localparam int KEY_W = 24;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [KEY_W-1:0] key_t;

    // One heap entry as stored in memory.
    typedef struct packed {
        id_t  id;
        key_t key;
    } entry_t;

endpackage

// ===== rtl/core/imhq_ram.sv =====
module imhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/indexed_min_heap_queue_unit.sv =====
// Channel  Dir  Width  Contents
// s_       in   40     opcode, point_id, new_key
// m_       out  48     out_id, out_key, out_valid, status, is_empty, entry_count
//
// Insert climbs from the new last slot; extract moves the last entry to the root and sinks it;
// change key climbs on a smaller key and sinks on an equal or larger one. The heap memory
// has a single read port, read once per level going up and twice per level going down.
// Reset clears the entry count and every in-heap mark; the memories need no clearing.
// A new request is taken as soon as the sequencer is idle, even while a result waits.
`include "indexed_min_heap_queue_unit_assert.svh"
module indexed_min_heap_queue_unit
    import imhq_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int MAX_POINTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [9:2] point_id, [33:10] new_key, [39:34] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_id, [31:8] out_key, [32] out_valid, [35:33] status,
    // [36] is_empty, [44:37] entry_count, [47:45] zero
    output logic [47:0] m_tdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = SW + 2;
    localparam int PW = $clog2(MAX_POINTS);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_XROOT  = 4'd1;
    localparam logic [3:0] S_XLAST  = 4'd2;
    localparam logic [3:0] S_CKSLOT = 4'd3;
    localparam logic [3:0] S_CKOLD  = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_CMP = 4'd6;
    localparam logic [3:0] S_DN_RL  = 4'd7;
    localparam logic [3:0] S_DN_RR  = 4'd8;
    localparam logic [3:0] S_DN_CMP = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         size_reg, size_next;
    logic [SW-1:0]         cur_reg, cur_next;
    entry_t                mv_reg, mv_next;
    entry_t                left_reg, left_next;
    id_t                   res_id_reg, res_id_next;
    key_t                  res_key_reg, res_key_next;
    logic                  res_valid_reg, res_valid_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [MAX_POINTS-1:0] mark_reg, mark_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [47:0]           m_tdata_reg, m_tdata_next;

    logic                  heap_we;
    logic [SW-1:0]         heap_waddr, heap_raddr;
    entry_t                heap_wdata, heap_rdata;
    logic                  slot_we;
    logic [PW-1:0]         slot_waddr, slot_raddr;
    logic [SW-1:0]         slot_wdata, slot_rdata;

    logic [1:0]            in_op;
    id_t                   in_id;
    key_t                  in_key;
    logic [PW-1:0]         in_idx;
    logic                  id_ok, in_mark, accept;
    logic [SW-1:0]         parent, slot_fix;
    logic [LW-1:0]         left_w, right_w;
    logic                  right_ok, take_right;
    entry_t                pick;
    logic [SW-1:0]         pick_slot;

    imhq_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imhq_ram #(.WIDTH(SW), .DEPTH(MAX_POINTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Request fields and presence lookup.
    assign in_op    = s_tdata[1:0];
    assign in_id    = s_tdata[9:2];
    assign in_key   = s_tdata[33:10];
    assign in_idx   = PW'(in_id);
    assign id_ok    = int'(in_id) < MAX_POINTS;
    assign in_mark  = id_ok && mark_reg[in_idx];
    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;

    // Tree geometry around the current slot.
    assign parent   = (cur_reg - SW'(1)) >> 1;
    assign left_w   = (LW'(cur_reg) << 1) + LW'(1);
    assign right_w  = left_w + LW'(1);
    assign right_ok = right_w < LW'(size_reg);
    assign slot_fix = (CW'(slot_rdata) >= size_reg) ? '0 : slot_rdata;

    // Child choice: the right child wins a tie.
    assign take_right = right_ok && !(left_reg.key < heap_rdata.key);
    assign pick       = take_right ? heap_rdata : left_reg;
    assign pick_slot  = take_right ? SW'(right_w) : SW'(left_w);

    // Sequencer for all four operations.
    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        cur_next        = cur_reg;
        mv_next         = mv_reg;
        left_next       = left_reg;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        mark_next       = mark_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        heap_we         = 1'b0;
        heap_waddr      = cur_reg;
        heap_wdata      = mv_reg;
        heap_raddr      = '0;
        slot_we         = 1'b0;
        slot_waddr      = PW'(mv_reg.id);
        slot_wdata      = cur_reg;
        slot_raddr      = in_idx;

        // The result register empties when the far side takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_id_next     = '0;
                    res_key_next    = '0;
                    res_valid_next  = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    unique case (in_op)
                        OP_CLEAR: begin
                            size_next = '0;
                            mark_next = '0;
                        end
                        OP_INSERT: begin
                            if (!id_ok) begin
                                res_status_next = ST_ABSENT;
                            end else if (in_mark) begin
                                res_status_next = ST_PRESENT;
                            end else if (size_reg >= CW'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                mv_next           = '{id: in_id, key: in_key};
                                cur_next          = SW'(size_reg);
                                size_next         = size_reg + CW'(1);
                                mark_next[in_idx] = 1'b1;
                                res_id_next       = in_id;
                                res_key_next      = in_key;
                                res_valid_next    = 1'b1;
                                state_next        = S_UP_RD;
                            end
                        end
                        OP_EXTRACT: begin
                            if (size_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                state_next = S_XROOT;
                            end
                        end
                        default: begin
                            if (!in_mark) begin
                                res_status_next = ST_ABSENT;
                            end else begin
                                mv_next.key    = in_key;
                                res_id_next    = in_id;
                                res_key_next   = in_key;
                                res_valid_next = 1'b1;
                                state_next     = S_CKSLOT;
                            end
                        end
                    endcase
                end
            end
            S_XROOT: begin
                // Root arrives; fetch the last entry.
                res_id_next                     = heap_rdata.id;
                res_key_next                    = heap_rdata.key;
                res_valid_next                  = 1'b1;
                mark_next[PW'(heap_rdata.id)]   = 1'b0;
                size_next                       = size_reg - CW'(1);
                heap_raddr                      = SW'(size_reg - CW'(1));
                state_next                      = S_XLAST;
            end
            S_XLAST: begin
                // The last entry moves to the root and sinks.
                mv_next  = heap_rdata;
                cur_next = '0;
                if (size_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RL;
                end
            end
            S_CKSLOT: begin
                cur_next   = slot_fix;
                heap_raddr = slot_fix;
                state_next = S_CKOLD;
            end
            S_CKOLD: begin
                // A smaller key climbs, an equal or larger one sinks.
                mv_next.id = heap_rdata.id;
                if (mv_reg.key < heap_rdata.key) begin
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DN_RL;
                end
            end
            S_UP_RD: begin
                heap_raddr = parent;
                if (cur_reg == '0) begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (mv_reg.key < heap_rdata.key) begin
                    // Parent moves down into the hole.
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = PW'(heap_rdata.id);
                    cur_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_RL: begin
                heap_raddr = SW'(left_w);
                if (left_w >= LW'(size_reg)) begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RR;
                end
            end
            S_DN_RR: begin
                left_next  = heap_rdata;
                heap_raddr = SW'(right_w);
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (pick.key < mv_reg.key) begin
                    // Smaller child moves up into the hole.
                    heap_we    = 1'b1;
                    heap_wdata = pick;
                    slot_we    = 1'b1;
                    slot_waddr = PW'(pick.id);
                    cur_next   = pick_slot;
                    state_next = S_DN_RL;
                end else begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, 8'(size_reg), size_reg == '0,
                                     res_status_reg, res_valid_reg,
                                     res_key_reg, res_id_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            size_reg     <= '0;
            mark_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            mark_reg     <= mark_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        mv_reg         <= mv_next;
        left_reg       <= left_next;
        res_id_reg     <= res_id_next;
        res_key_reg    <= res_key_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The count never passes the capacity.
    `IMHQ_ASSERT_IMP(a_size_cap, aclk, aresetn, 1'b1, size_reg <= CW'(CAPACITY))
    // A climbing entry always sits inside the heap and below the root.
    `IMHQ_ASSERT_IMP(a_up_slot, aclk, aresetn, state_reg == S_UP_CMP,
        cur_reg != '0 && CW'(cur_reg) < size_reg)
    // A clear request empties the heap at once.
    `IMHQ_ASSERT_NXT(a_clear, aclk, aresetn,
        s_tvalid && s_tready && s_tdata[1:0] == OP_CLEAR, size_reg == '0)

endmodule

// ===== bench/imhq_checker.sv =====
`timescale 1ns / 100ps
module imhq_checker
    import imhq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [1:0] opcode, [9:2] point_id, [33:10] new_key, [39:34] zero
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_id, [31:8] out_key, [32] out_valid, [35:33] status,
    // [36] is_empty, [44:37] entry_count, [47:45] zero
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending_results,
    output int          results_seen
);

    localparam int CAP = 128;

    // Mirror of the heap contents.
    key_t       mirror_keys [CAP];
    id_t        mirror_ids  [CAP];
    logic [7:0] mirror_slot [256];
    logic       mirror_mark [256];
    int         mirror_size;

    logic [47:0] expected_results [$];

    function automatic void place(int slot, id_t id, key_t key);
        mirror_keys[slot] = key;
        mirror_ids[slot]  = id;
        mirror_slot[id]   = slot[7:0];
    endfunction

    function automatic void climb(int slot);
        id_t  id;
        key_t key;
        int   parent;
        id  = mirror_ids[slot];
        key = mirror_keys[slot];
        while (slot > 0) begin
            parent = (slot - 1) >> 1;
            if (key >= mirror_keys[parent]) break;
            place(slot, mirror_ids[parent], mirror_keys[parent]);
            slot = parent;
        end
        place(slot, id, key);
    endfunction

    function automatic void sink(int slot);
        id_t  id;
        key_t key;
        int   pick;
        id  = mirror_ids[slot];
        key = mirror_keys[slot];
        forever begin
            if (2 * slot + 1 >= mirror_size) break;
            pick = 2 * slot + 1;
            if (pick + 1 < mirror_size && !(mirror_keys[pick] < mirror_keys[pick + 1]))
                pick = pick + 1;
            if (mirror_keys[pick] >= key) break;
            place(slot, mirror_ids[pick], mirror_keys[pick]);
            slot = pick;
        end
        place(slot, id, key);
    endfunction

    // Apply one request to the mirror and return the packed result it should give.
    function automatic logic [47:0] heap_outcome(logic [39:0] req);
        logic [1:0] op;
        id_t        pid;
        key_t       key, rkey;
        id_t        rid;
        logic       ok;
        logic [2:0] st;
        int         slot;
        key_t       old;
        op  = req[1:0];
        pid = req[9:2];
        key = req[33:10];
        rid = '0;
        rkey = '0;
        ok  = 1'b0;
        st  = ST_OK;
        case (op)
            OP_CLEAR: begin
                mirror_size = 0;
                foreach (mirror_mark[i]) mirror_mark[i] = 1'b0;
            end
            OP_INSERT: begin
                if (mirror_mark[pid]) st = ST_PRESENT;
                else if (mirror_size >= CAP) st = ST_FULL;
                else begin
                    place(mirror_size, pid, key);
                    mirror_mark[pid] = 1'b1;
                    mirror_size++;
                    climb(mirror_size - 1);
                    rid = pid; rkey = key; ok = 1'b1;
                end
            end
            OP_EXTRACT: begin
                if (mirror_size == 0) st = ST_EMPTY;
                else begin
                    rid = mirror_ids[0];
                    rkey = mirror_keys[0];
                    ok = 1'b1;
                    mirror_mark[rid] = 1'b0;
                    mirror_size--;
                    if (mirror_size > 0) begin
                        place(0, mirror_ids[mirror_size], mirror_keys[mirror_size]);
                        sink(0);
                    end
                end
            end
            default: begin
                if (!mirror_mark[pid]) st = ST_ABSENT;
                else begin
                    slot = mirror_slot[pid];
                    if (slot >= mirror_size) slot = 0;
                    old = mirror_keys[slot];
                    mirror_keys[slot] = key;
                    if (key < old) climb(slot);
                    else sink(slot);
                    rid = pid; rkey = key; ok = 1'b1;
                end
            end
        endcase
        return {3'b000, mirror_size[7:0], (mirror_size == 0), st, ok, rkey, rid};
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, field, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count      = 0;
        results_seen    = 0;
        pending_results = 0;
        mirror_size     = 0;
        foreach (mirror_mark[i]) mirror_mark[i] = 1'b0;
        foreach (mirror_slot[i]) mirror_slot[i] = '0;
        foreach (mirror_keys[i]) begin
            mirror_keys[i] = '0;
            mirror_ids[i]  = '0;
        end
    end

    // Predict on accepted requests, compare on accepted results.
    always @(posedge aclk) begin
        logic [47:0] want;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_results.push_back(heap_outcome(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata[31:0]), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want[7:0])
                        report_mismatch("out_id", m_tdata[7:0], want[7:0]);
                    if (m_tdata[31:8] !== want[31:8])
                        report_mismatch("out_key", m_tdata[31:8], want[31:8]);
                    if (m_tdata[32] !== want[32])
                        report_mismatch("out_valid", m_tdata[32], want[32]);
                    if (m_tdata[35:33] !== want[35:33])
                        report_mismatch("status", m_tdata[35:33], want[35:33]);
                    if (m_tdata[36] !== want[36])
                        report_mismatch("is_empty", m_tdata[36], want[36]);
                    if (m_tdata[44:37] !== want[44:37])
                        report_mismatch("entry_count", m_tdata[44:37], want[44:37]);
                end
                results_seen++;
            end
            pending_results = expected_results.size();
        end
    end

endmodule

// ===== bench/tb_indexed_min_heap_queue_unit.sv =====
`timescale 1ns / 100ps
module tb_indexed_min_heap_queue_unit;
    import imhq_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] opcode, [9:2] point_id, [33:10] new_key, [39:34] zero
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [7:0] out_id, [31:8] out_key, [32] out_valid, [35:33] status,
    // [36] is_empty, [44:37] entry_count, [47:45] zero
    logic [47:0] m_tdata;
    int          fail_count, pending_results, results_seen;
    int          send_idle_pct, recv_idle_pct;
    int          requests_sent;
    logic [7:0]  live_ids [$];

    indexed_min_heap_queue_unit dut (.*);
    imhq_checker checker_i (.*);

    // Clock of 20 ns.
    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    // Receiver readiness changes at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("timeout");
        $display("indexed_min_heap_queue_unit regression: fail");
        $finish;
    end

    // Present one request and hold it until accepted; the valid line stays up
    // for a request that follows straight on.
    task automatic send_request(logic [1:0] op, logic [7:0] pid, key_t key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, pid, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic random_request();
        int   pick;
        logic [7:0] pid;
        key_t key;
        pick = $urandom_range(99);
        key  = ($urandom_range(3) == 0) ? key_t'($urandom_range(15)) : key_t'($urandom);
        pid  = 8'($urandom);
        if (pick < 2) send_request(OP_CLEAR, pid, key);
        else if (pick < 45) send_request(OP_INSERT, pid, key);
        else if (pick < 75) send_request(OP_EXTRACT, pid, key);
        else begin
            // Change key mostly on an id that is probably present.
            if (live_ids.size() > 0 && pick < 95)
                pid = live_ids[$urandom_range(live_ids.size()-1)];
            send_request(OP_CHANGE, pid, key);
        end
        if (pick >= 2 && pick < 45) live_ids.push_back(pid);
        if (live_ids.size() > 64) void'(live_ids.pop_front());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        requests_sent = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty cases, extremes, ties, fill to capacity.
        send_request(OP_EXTRACT, 8'hff, '1);
        send_request(OP_CHANGE, 8'h00, '0);
        send_request(OP_INSERT, 8'hff, '1);
        send_request(OP_INSERT, 8'h00, '0);
        send_request(OP_INSERT, 8'h00, 24'h5);
        send_request(OP_INSERT, 8'h55, 24'h800000);
        send_request(OP_INSERT, 8'haa, 24'h800000);
        send_request(OP_CHANGE, 8'hff, '0);
        send_request(OP_CHANGE, 8'h00, '1);
        send_request(OP_CHANGE, 8'h55, 24'h800000);
        send_request(OP_CHANGE, 8'h12, 24'h1);
        repeat (6) send_request(OP_EXTRACT, 8'h00, '0);
        for (int i = 0; i < 129; i++) send_request(OP_INSERT, 8'(i), key_t'($urandom));
        send_request(OP_CLEAR, 8'hff, '1);
        send_request(OP_INSERT, 8'h03, 24'h10);
        send_request(OP_EXTRACT, 8'h00, '0);
        drain();

        // Random phases with differing idle patterns.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 13 : 0;
            for (int n = 0; n < 384; n++) begin
                random_request();
                // Hold off until every result is in.
                if (n == 200) drain();
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        $display("sent %0d requests and checked %0d results across three idle patterns",
                 requests_sent, results_seen);
        if (fail_count == 0 && pending_results == 0) begin
            $display("indexed_min_heap_queue_unit regression: pass");
        end else begin
            $display("indexed_min_heap_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
